// File: rtl/lpcs_pkg.sv
// ----------------------------------------------------------------------------
// lpcs_pkg: shared types and constants
// Field widths, item layout, codes and the MAC control struct for the
// pulse excited LPC synthesis block.
// ----------------------------------------------------------------------------
package lpcs_pkg;

  // Field widths
  localparam int IDX_W   = 4;
  localparam int COEF_W  = 16;
  localparam int SAMP_W  = 16;
  localparam int GAIN_W  = 15;
  localparam int MIX_W   = 16;
  localparam int PER_W   = 9;
  localparam int HIST_W  = 24;

  // Item layout in in_tdata, lowest bit up
  localparam int IDX_LSB  = 0;
  localparam int COEF_LSB = IDX_LSB + IDX_W;
  localparam int RES_LSB  = COEF_LSB + COEF_W;
  localparam int GAIN_LSB = RES_LSB + SAMP_W;
  localparam int MIX_LSB  = GAIN_LSB + GAIN_W;
  localparam int PER_LSB  = MIX_LSB + MIX_W;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 24;

  // Shared multiplier operands: 18-bit signed by 24-bit signed
  localparam int OPA_W  = 18;
  localparam int OPB_W  = 24;
  localparam int PROD_W = OPA_W + OPB_W;

  // Mix weight in Q15, clamped value needs one more bit
  localparam int MIXC_W = MIX_W + 1;
  localparam logic [MIXC_W-1:0] Q15_ONE = 17'd32768;
  localparam int Q15_SHIFT = 15;

  // Q12 coefficient rounding
  localparam int Q12_SHIFT = 12;
  localparam int Q12_HALF  = 2048;

  // Output saturation bounds
  localparam int HIST_MAX = 8388607;
  localparam int HIST_MIN = -8388608;

  // Pulse stays on for this many samples after a restart
  localparam int PULSE_WIDTH = 3;

  // Request kinds carried in in_tuser
  localparam logic REQ_COEF   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // MAC control: load writes the product, accum adds it
  typedef struct packed {
    logic load;
    logic accum;
  } mac_ctl_t;

endpackage

// File: rtl/pulse_excited_lpc_synthesis_top.sv
// ----------------------------------------------------------------------------
// pulse_excited_lpc_synthesis_top: pulse excited LPC synthesis filter
// All-pole synthesis with a pulse/residual cross-faded excitation, built
// around one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the in_ stream. in_tuser selects the kind: a coefficient
//   load writes one Q12 tap (taps at or beyond ORDER are ignored); a sample
//   item carries residual, gain, mix weight and pulse spacing and yields one
//   24-bit synthesized sample on the out_ stream. A sample item is taken in
//   S_IDLE, cross-faded on the shared multiplier in S_MIX0 and S_MIX1,
//   filtered one tap each cycle through the shared multiplier (tap 0 in
//   S_VCAP, the rest in S_TAP), then rounded, saturated and shifted into
//   the history in S_FIN. in_tready is low after the accepting edge until
//   the item is done, so no new item is taken while a sample is in flight.
//   out_tvalid rises in the same cycle that in_tready returns.
//   The result sits in an output register; the next item is accepted while
//   it waits. If the receiver still holds off when the following result is
//   ready, the block holds in its final step until the register frees.
//   Reset clears the history, the pulse counter and the output valid flag.
//   Coefficients are not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module pulse_excited_lpc_synthesis_top #(
  parameter int ORDER = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // fields from bit 0: coef_index[4], coef_value[16], residual[16],
  // pulse_gain[15], mix_weight[16], pulse_spacing[9], zero pad[4]
  input  logic [79:0] in_tdata,
  // fields from bit 0: req_type[1]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // fields from bit 0: synth_sample[24]
  output logic [23:0] out_tdata
);
  import lpcs_pkg::*;

  localparam int TAP_W = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam int ACC_W = PROD_W + $clog2(ORDER + 1);
  localparam int PRED_W = ACC_W - Q12_SHIFT;
  localparam int YS_W  = PRED_W + 1;
  localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(ORDER - 1);
  localparam logic signed [YS_W-1:0] Y_MAX = YS_W'(HIST_MAX);
  localparam logic signed [YS_W-1:0] Y_MIN = YS_W'(HIST_MIN);
  localparam logic signed [ACC_W-1:0] RND_Q12 = ACC_W'(Q12_HALF);
  localparam logic signed [ACC_W-1:0] RND_Q15 = ACC_W'((1 << Q15_SHIFT) - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_MIX0, S_MIX1, S_VCAP, S_TAP, S_FIN
  } state_t;

  // Unpack the input item
  logic [IDX_W-1:0]         f_idx;
  logic signed [COEF_W-1:0] f_coef;
  logic signed [SAMP_W-1:0] f_res;
  logic [GAIN_W-1:0]        f_gain;
  logic [MIX_W-1:0]         f_mix;
  logic [PER_W-1:0]         f_per;

  assign f_idx  = in_tdata[IDX_LSB  +: IDX_W];
  assign f_coef = in_tdata[COEF_LSB +: COEF_W];
  assign f_res  = in_tdata[RES_LSB  +: SAMP_W];
  assign f_gain = in_tdata[GAIN_LSB +: GAIN_W];
  assign f_mix  = in_tdata[MIX_LSB  +: MIX_W];
  assign f_per  = in_tdata[PER_LSB  +: PER_W];

  state_t                   state_r;
  logic [TAP_W-1:0]         tap_r;
  logic signed [SAMP_W-1:0] res_r;
  logic [MIXC_W-1:0]        mix_r;
  logic signed [SAMP_W-1:0] v_r;
  logic                     out_valid_r;
  logic [OUT_DATA_W-1:0]    out_data_r;
  logic signed [COEF_W-1:0] coef_r [ORDER];
  logic signed [HIST_W-1:0] hist_r [ORDER];

  logic                     in_acc;
  logic                     sample_acc;
  logic                     out_free;
  logic                     out_load;
  logic [GAIN_W-1:0]        exc;
  mac_ctl_t                 mac_ctl;
  logic signed [OPA_W-1:0]  op_a;
  logic signed [OPB_W-1:0]  op_b;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_v;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [PRED_W-1:0] pred;
  logic signed [YS_W-1:0]   y_sum;
  logic signed [HIST_W-1:0] y_sat;
  logic signed [COEF_W-1:0] coef_rd;
  logic signed [HIST_W-1:0] hist_rd;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign sample_acc = in_acc && (in_tuser == REQ_SAMPLE);
  assign out_free   = !out_valid_r || out_tready;
  assign out_load   = (state_r == S_FIN) && out_free;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  lpcs_pulse u_pulse (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (sample_acc),
    .gain   (f_gain),
    .period (f_per),
    .exc    (exc)
  );

  lpcs_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (acc)
  );

  assign coef_rd = coef_r[tap_r];
  assign hist_rd = hist_r[tap_r];

  // Feed the shared multiplier according to the step
  always_comb begin
    mac_ctl = '0;
    op_a    = '0;
    op_b    = '0;
    unique case (state_r)
      S_MIX0: begin
        mac_ctl.load = 1'b1;
        op_a = $signed({1'b0, Q15_ONE - mix_r});
        op_b = {{(OPB_W-SAMP_W){res_r[SAMP_W-1]}}, res_r};
      end
      S_MIX1: begin
        mac_ctl.accum = 1'b1;
        op_a = $signed({1'b0, mix_r});
        op_b = $signed({{(OPB_W-GAIN_W){1'b0}}, exc});
      end
      S_VCAP: begin
        mac_ctl.load = 1'b1;
        op_a = {{(OPA_W-COEF_W){coef_rd[COEF_W-1]}}, coef_rd};
        op_b = hist_rd;
      end
      S_TAP: begin
        mac_ctl.accum = 1'b1;
        op_a = {{(OPA_W-COEF_W){coef_rd[COEF_W-1]}}, coef_rd};
        op_b = hist_rd;
      end
      default: begin
        mac_ctl = '0;
      end
    endcase
  end

  // Cross-fade divide by 2^15, truncated toward zero
  assign acc_v = acc + (acc[ACC_W-1] ? RND_Q15 : '0);

  // Q12 round half up, add excitation, saturate
  assign acc_rnd = acc + RND_Q12;
  assign pred    = acc_rnd[ACC_W-1:Q12_SHIFT];
  assign y_sum   = {pred[PRED_W-1], pred}
                 + {{(YS_W-SAMP_W){v_r[SAMP_W-1]}}, v_r};

  always_comb begin
    priority if (y_sum > Y_MAX) begin
      y_sat = HIST_W'(HIST_MAX);
    end else if (y_sum < Y_MIN) begin
      y_sat = HIST_W'(HIST_MIN);
    end else begin
      y_sat = y_sum[HIST_W-1:0];
    end
  end

  // Coefficient table: written by load items, no reset
  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser == REQ_COEF) && (32'(f_idx) < ORDER)) begin
      coef_r[TAP_W'(f_idx)] <= f_coef;
    end
  end

  // Sequencer, history and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tap_r       <= '0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < ORDER; j++) begin
        hist_r[j] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          tap_r <= '0;
          if (sample_acc) begin
            res_r   <= f_res;
            mix_r   <= (f_mix > MIX_W'(Q15_ONE)) ? Q15_ONE : {1'b0, f_mix};
            state_r <= S_MIX0;
          end
        end
        S_MIX0: begin
          state_r <= S_MIX1;
        end
        S_MIX1: begin
          state_r <= S_VCAP;
        end
        S_VCAP: begin
          // capture the faded sample while tap 0 loads the accumulator
          v_r <= acc_v[Q15_SHIFT +: SAMP_W];
          if (tap_r == LAST_TAP) begin
            state_r <= S_FIN;
          end else begin
            tap_r   <= tap_r + 1'b1;
            state_r <= S_TAP;
          end
        end
        S_TAP: begin
          if (tap_r == LAST_TAP) begin
            state_r <= S_FIN;
          end else begin
            tap_r <= tap_r + 1'b1;
          end
        end
        S_FIN: begin
          // hold until the output register can take the sample
          if (out_load) begin
            out_data_r <= y_sat;
            for (int j = ORDER - 1; j > 0; j--) begin
              hist_r[j] <= hist_r[j-1];
            end
            hist_r[0] <= y_sat;
            state_r   <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/lpcs_mac.sv
// ----------------------------------------------------------------------------
// lpcs_mac: shared multiply-accumulate unit
// One signed multiplier feeding a registered accumulator, used for both the
// cross-fade and every filter tap.
// ----------------------------------------------------------------------------
module lpcs_mac #(
  parameter int ACC_W = 47
) (
  input  logic                              clk,
  input  lpcs_pkg::mac_ctl_t                ctl,
  input  logic signed [lpcs_pkg::OPA_W-1:0] op_a,
  input  logic signed [lpcs_pkg::OPB_W-1:0] op_b,
  output logic signed [ACC_W-1:0]           acc
);
  import lpcs_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_r;

  assign prod     = op_a * op_b;
  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign acc      = acc_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc_r <= prod_ext;
    end else if (ctl.accum) begin
      acc_r <= acc_r + prod_ext;
    end
  end

endmodule

// File: rtl/lpcs_pulse.sv
// ----------------------------------------------------------------------------
// lpcs_pulse: pulse excitation generator
// Counts samples against the pitch period and emits the gain for the first
// samples of each period, zero otherwise.
// ----------------------------------------------------------------------------
module lpcs_pulse (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step,
  input  logic [lpcs_pkg::GAIN_W-1:0]      gain,
  input  logic [lpcs_pkg::PER_W-1:0]       period,
  output logic [lpcs_pkg::GAIN_W-1:0]      exc
);
  import lpcs_pkg::*;

  localparam logic [PER_W-1:0] WIDTH_CNT = PER_W'(PULSE_WIDTH);

  logic [PER_W-1:0]  count_r;
  logic [GAIN_W-1:0] exc_r;

  assign exc = exc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (step) begin
      // restart on reaching the period, including a period that shrank
      if (count_r >= period) begin
        count_r <= '0;
      end else begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (count_r >= period || count_r < WIDTH_CNT) begin
        exc_r <= gain;
      end else begin
        exc_r <= '0;
      end
    end
  end

endmodule
